// ===== rtl/nwn_pkg.sv =====
// Package for the nearest weight neighbourhood search.
// Holds field widths, reset values, codes, state and control types.
// No dependencies; compiled first.
package nwn_pkg;

   // Item field widths
   localparam int COMP_BITS      = 8;
   localparam int NUM_COMPS      = 4;
   localparam int SLOT_BITS      = 8;
   localparam int SLOT_SPAN      = 1 << SLOT_BITS;
   localparam int RANK_BITS      = 5;

   // Squared distance over all components
   localparam int DIST_W         = 2 * COMP_BITS + $clog2(NUM_COMPS);

   // Register widths and reset values
   localparam int VCOUNT_BITS    = 9;
   localparam int OCOUNT_BITS    = 3;
   localparam int NCOUNT_BITS    = 6;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;

   localparam logic [VCOUNT_BITS-1:0] RESET_VECTOR_COUNT    = 9'd256;
   localparam logic [OCOUNT_BITS-1:0] RESET_OBJECTIVE_COUNT = 3'd3;
   localparam logic [NCOUNT_BITS-1:0] RESET_NEIGHBOR_COUNT  = 6'd20;

   // Default sizing
   localparam int DEF_MAX_VECTORS   = 256;
   localparam int DEF_MAX_NEIGHBORS = 32;

   typedef logic [COMP_BITS-1:0] comp_type;
   typedef comp_type [NUM_COMPS-1:0] weight_type;

   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VECTOR_COUNT    = 2'd0,
      CSR_OBJECTIVE_COUNT = 2'd1,
      CSR_NEIGHBOR_COUNT  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REF,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   // Commands to the row of sorting cells
   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== rtl/nwn_channel_if.sv =====
// Request and response channel interfaces (valid/ready handshake).
// Depends on nwn_pkg for the field widths.
interface nwn_req_if;
   import nwn_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [SLOT_BITS-1:0] slot;
   logic [COMP_BITS-1:0] comp_a;
   logic [COMP_BITS-1:0] comp_b;
   logic [COMP_BITS-1:0] comp_c;
   logic [COMP_BITS-1:0] comp_d;

   modport source (output valid, action, slot, comp_a, comp_b, comp_c, comp_d,
                   input ready);
   modport sink   (input valid, action, slot, comp_a, comp_b, comp_c, comp_d,
                   output ready);
endinterface

interface nwn_rsp_if;
   import nwn_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [SLOT_BITS-1:0] neighbor_index;
   logic [RANK_BITS-1:0] neighbor_rank;
   logic                 last_flag;

   modport source (output valid, neighbor_index, neighbor_rank, last_flag,
                   input ready);
   modport sink   (input valid, neighbor_index, neighbor_rank, last_flag,
                   output ready);
endinterface

// ===== rtl/nwn_store.sv =====
// Weight vector memory: one write port, one registered read port.
// Depends on nwn_pkg for the vector type.
module nwn_store #(
   parameter int MAX_VECTORS = nwn_pkg::DEF_MAX_VECTORS,
   parameter int ADDR_W      = $clog2(nwn_pkg::DEF_MAX_VECTORS)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  nwn_pkg::weight_type wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output nwn_pkg::weight_type rd_data_ff
);
   import nwn_pkg::*;

   weight_type weight_mem [MAX_VECTORS];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         weight_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= weight_mem[rd_addr];
      end
   end

endmodule

// ===== rtl/nwn_dist.sv =====
// Squared Euclidean distance pipeline: abs diff, square, sum (three stages).
// Depends on nwn_pkg; fed by the registered read port of nwn_store.
module nwn_dist #(
   parameter int IDX_W = $clog2(nwn_pkg::DEF_MAX_VECTORS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           ref_load,
   input  nwn_pkg::weight_type            rd_data,
   input  logic                           in_valid,
   input  logic [IDX_W-1:0]               in_idx,
   input  logic [nwn_pkg::OCOUNT_BITS-1:0] ncomp,
   output logic                           cand_valid,
   output logic [nwn_pkg::DIST_W-1:0]     cand_dist,
   output logic [IDX_W-1:0]               cand_idx,
   output logic                           busy
);
   import nwn_pkg::*;

   localparam int SQ_W = 2 * COMP_BITS;

   weight_type                    ref_ff;
   weight_type                    diff_in;
   weight_type                    diff_ff;
   logic                          diff_valid_ff;
   logic [IDX_W-1:0]              diff_idx_ff;
   logic [NUM_COMPS-1:0][SQ_W-1:0] sq_in;
   logic [NUM_COMPS-1:0][SQ_W-1:0] sq_ff;
   logic                          sq_valid_ff;
   logic [IDX_W-1:0]              sq_idx_ff;
   logic [DIST_W-1:0]             sum_in;
   logic                          cand_valid_ff;
   logic [DIST_W-1:0]             cand_dist_ff;
   logic [IDX_W-1:0]              cand_idx_ff;

   // Reference vector, captured the cycle after its read
   always_ff @(posedge clock) begin
      if (ref_load) begin
         ref_ff <= rd_data;
      end
   end

   // Absolute differences, unused components forced to zero
   always_comb begin
      for (int k = 0; k < NUM_COMPS; k++) begin
         if (32'(ncomp) <= k) begin
            diff_in[k] = '0;
         end else if (rd_data[k] > ref_ff[k]) begin
            diff_in[k] = rd_data[k] - ref_ff[k];
         end else begin
            diff_in[k] = ref_ff[k] - rd_data[k];
         end
      end
   end

   // Squares
   always_comb begin
      for (int k = 0; k < NUM_COMPS; k++) begin
         sq_in[k] = SQ_W'(diff_ff[k]) * SQ_W'(diff_ff[k]);
      end
   end

   // Sum of squares
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < NUM_COMPS; k++) begin
         sum_in = sum_in + DIST_W'(sq_ff[k]);
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
         sq_valid_ff   <= 1'b0;
         cand_valid_ff <= 1'b0;
      end else begin
         diff_valid_ff <= in_valid;
         sq_valid_ff   <= diff_valid_ff;
         cand_valid_ff <= sq_valid_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      diff_ff      <= diff_in;
      diff_idx_ff  <= in_idx;
      sq_ff        <= sq_in;
      sq_idx_ff    <= diff_idx_ff;
      cand_dist_ff <= sum_in;
      cand_idx_ff  <= sq_idx_ff;
   end

   assign cand_valid = cand_valid_ff;
   assign cand_dist  = cand_dist_ff;
   assign cand_idx   = cand_idx_ff;
   assign busy       = diff_valid_ff | sq_valid_ff | cand_valid_ff;

endmodule

// ===== rtl/nwn_cell.sv =====
// One cell of the sorted insertion row: holds one (distance, index) entry.
// Depends on nwn_pkg for the control struct and distance width.
module nwn_cell #(
   parameter int IDX_W = $clog2(nwn_pkg::DEF_MAX_VECTORS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  nwn_pkg::cell_ctrl_type     ctrl,
   input  logic [nwn_pkg::DIST_W-1:0] cand_dist,
   input  logic [IDX_W-1:0]           cand_idx,
   input  logic                       prev_take,
   input  logic                       prev_valid,
   input  logic [nwn_pkg::DIST_W-1:0] prev_dist,
   input  logic [IDX_W-1:0]           prev_idx,
   input  logic                       next_valid,
   input  logic [nwn_pkg::DIST_W-1:0] next_dist,
   input  logic [IDX_W-1:0]           next_idx,
   output logic                       take,
   output logic                       valid,
   output logic [nwn_pkg::DIST_W-1:0] entry_dist,
   output logic [IDX_W-1:0]           idx
);
   import nwn_pkg::*;

   logic              valid_ff, valid_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   // Candidate belongs here or earlier; strict less keeps the lower index first
   assign take = ctrl.insert && (!valid_ff || (cand_dist < dist_ff));

   always_comb begin
      valid_in = valid_ff;
      dist_in  = dist_ff;
      idx_in   = idx_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         // drain towards the head
         valid_in = next_valid;
         dist_in  = next_dist;
         idx_in   = next_idx;
      end else if (prev_take) begin
         // pushed down by an insert above; an empty entry stays empty
         valid_in = prev_valid;
         dist_in  = prev_dist;
         idx_in   = prev_idx;
      end else if (take) begin
         valid_in = 1'b1;
         dist_in  = cand_dist;
         idx_in   = cand_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      idx_ff  <= idx_in;
   end

   assign valid      = valid_ff;
   assign entry_dist = dist_ff;
   assign idx        = idx_ff;

endmodule

// ===== rtl/nearest_weight_neighborhood.sv =====
// Nearest weight neighbourhood search, top level.
// Depends on nwn_pkg, nwn_channel_if, nwn_store, nwn_dist and nwn_cell.
//
// req_if carries one item per handshake. A load item (action 0) writes its four
// components into the slot and gives no result. A query item names a slot and
// returns the nearest stored vectors, nearest first, ties to the lower index,
// one rsp_if item each, last_flag on the final one. csr_* writes the three
// registers; write them only while the block is idle.
// A query reads its reference vector, then sweeps the searched vectors through
// the memory read port at one per cycle (vector_count of them, capped at
// MAX_VECTORS) and waits for the distance pipeline to empty before the first
// result shows. Each candidate enters the row of MAX_NEIGHBORS sorting cells as
// it leaves the pipeline. Results leave at one per cycle; a stalled rsp_if holds
// the head item and the row. req_if is not ready from query acceptance until the
// last result is taken; a query asking for no neighbours gives no result and
// leaves the block idle.
// Reset clears the control state and restores the register defaults; the
// weight memory is not cleared and holds whatever it held until loaded.
module nearest_weight_neighborhood #(
   parameter int MAX_VECTORS   = nwn_pkg::DEF_MAX_VECTORS,
   parameter int MAX_NEIGHBORS = nwn_pkg::DEF_MAX_NEIGHBORS
) (
   input  logic                              clock,
   input  logic                              reset,
   nwn_req_if.sink                           req_if,
   nwn_rsp_if.source                         rsp_if,
   input  logic                              csr_write_en,
   input  logic [nwn_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [nwn_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import nwn_pkg::*;

   localparam int ADDR_W = $clog2(MAX_VECTORS);
   localparam int CNT_W  = $clog2(MAX_VECTORS + 1);
   localparam int NRES_W = $clog2(MAX_NEIGHBORS + 1);
   localparam int ROW    = MAX_NEIGHBORS + 2;

   state_type state_ff, state_in;

   logic [VCOUNT_BITS-1:0] vector_count_ff, vector_count_in;
   logic [OCOUNT_BITS-1:0] objective_count_ff, objective_count_in;
   logic [NCOUNT_BITS-1:0] neighbor_count_ff, neighbor_count_in;

   logic [ADDR_W-1:0]      slot_ff, slot_in;
   logic [CNT_W-1:0]       nvec_ff, nvec_in;
   logic [OCOUNT_BITS-1:0] ncomp_ff, ncomp_in;
   logic [NRES_W-1:0]      nres_ff, nres_in;
   logic [CNT_W-1:0]       sweep_ff, sweep_in;
   logic [NRES_W-1:0]      rank_ff, rank_in;
   logic                   s1_valid_ff;
   logic [ADDR_W-1:0]      s1_idx_ff;
   logic                   ref_rd_ff;

   logic [CNT_W-1:0]       nvec_calc;
   logic [NRES_W-1:0]      nres_cap;
   logic [NRES_W-1:0]      nres_calc;
   logic [OCOUNT_BITS-1:0] ncomp_calc;

   logic                   req_fire;
   logic                   rsp_fire;
   logic                   is_query;
   logic                   sweep_issue;
   logic                   sweep_done;
   logic                   rank_last;

   logic                   wr_en;
   weight_type             wr_data;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   weight_type             rd_data;

   logic                   cand_valid;
   logic [DIST_W-1:0]      cand_dist;
   logic [ADDR_W-1:0]      cand_idx;
   logic                   dist_busy;

   cell_ctrl_type          cell_ctrl;
   logic [ADDR_W-1:0]      slot_mod [SLOT_SPAN];

   logic                   take_row  [ROW];
   logic                   valid_row [ROW];
   logic [DIST_W-1:0]      dist_row  [ROW];
   logic [ADDR_W-1:0]      idx_row   [ROW];

   // Slot reduction table, worked out at elaboration
   for (genvar g = 0; g < SLOT_SPAN; g++) begin : g_slot_mod
      assign slot_mod[g] = ADDR_W'(g % MAX_VECTORS);
   end

   // Handshakes and query set-up
   assign req_fire    = req_if.valid && req_if.ready;
   assign rsp_fire    = rsp_if.valid && rsp_if.ready;
   assign is_query    = (req_if.action == ACT_QUERY);
   assign sweep_issue = (state_ff == ST_SWEEP) && (sweep_ff < nvec_ff);
   assign sweep_done  = (sweep_ff == nvec_ff) && !s1_valid_ff && !dist_busy;
   assign rank_last   = (rank_ff == nres_ff - NRES_W'(1));

   assign nvec_calc  = (32'(vector_count_ff) > MAX_VECTORS) ?
                       CNT_W'(MAX_VECTORS) : CNT_W'(vector_count_ff);
   assign nres_cap   = (32'(neighbor_count_ff) > MAX_NEIGHBORS) ?
                       NRES_W'(MAX_NEIGHBORS) : NRES_W'(neighbor_count_ff);
   assign nres_calc  = (32'(nres_cap) > 32'(nvec_calc)) ?
                       NRES_W'(nvec_calc) : nres_cap;
   assign ncomp_calc = (32'(objective_count_ff) > NUM_COMPS) ?
                       OCOUNT_BITS'(NUM_COMPS) : objective_count_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_query && (nres_calc != '0)) begin
               state_in = ST_REF;
            end
         end
         ST_REF: begin
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_fire && rank_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      req_if.ready     = 1'b0;
      rsp_if.valid     = 1'b0;
      rd_en            = 1'b0;
      rd_addr          = sweep_ff[ADDR_W-1:0];
      cell_ctrl.clear  = 1'b0;
      cell_ctrl.insert = cand_valid;
      cell_ctrl.shift  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         ST_REF: begin
            rd_en           = 1'b1;
            rd_addr         = slot_ff;
            cell_ctrl.clear = 1'b1;
         end
         ST_SWEEP: begin
            rd_en = sweep_issue;
         end
         ST_DRAIN: begin
            rsp_if.valid    = 1'b1;
            cell_ctrl.shift = rsp_if.ready;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   // Configuration registers
   always_comb begin
      vector_count_in    = vector_count_ff;
      objective_count_in = objective_count_ff;
      neighbor_count_in  = neighbor_count_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_VECTOR_COUNT:    vector_count_in    = csr_write_data;
            CSR_OBJECTIVE_COUNT: objective_count_in = csr_write_data[OCOUNT_BITS-1:0];
            CSR_NEIGHBOR_COUNT:  neighbor_count_in  = csr_write_data[NCOUNT_BITS-1:0];
            default: begin
               vector_count_in = vector_count_ff;
            end
         endcase
      end
   end

   // Query context and counters
   always_comb begin
      slot_in  = slot_ff;
      nvec_in  = nvec_ff;
      ncomp_in = ncomp_ff;
      nres_in  = nres_ff;
      sweep_in = sweep_ff;
      rank_in  = rank_ff;
      if (req_fire && is_query) begin
         slot_in  = slot_mod[req_if.slot];
         nvec_in  = nvec_calc;
         ncomp_in = ncomp_calc;
         nres_in  = nres_calc;
      end
      if (state_ff == ST_REF) begin
         sweep_in = '0;
         rank_in  = '0;
      end else if (sweep_issue) begin
         sweep_in = sweep_ff + CNT_W'(1);
      end
      if (rsp_fire) begin
         rank_in = rank_ff + NRES_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         vector_count_ff    <= RESET_VECTOR_COUNT;
         objective_count_ff <= RESET_OBJECTIVE_COUNT;
         neighbor_count_ff  <= RESET_NEIGHBOR_COUNT;
         s1_valid_ff        <= 1'b0;
         ref_rd_ff          <= 1'b0;
         sweep_ff           <= '0;
         rank_ff            <= '0;
      end else begin
         state_ff           <= state_in;
         vector_count_ff    <= vector_count_in;
         objective_count_ff <= objective_count_in;
         neighbor_count_ff  <= neighbor_count_in;
         s1_valid_ff        <= sweep_issue;
         ref_rd_ff          <= (state_ff == ST_REF);
         sweep_ff           <= sweep_in;
         rank_ff            <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      nvec_ff   <= nvec_in;
      ncomp_ff  <= ncomp_in;
      nres_ff   <= nres_in;
      s1_idx_ff <= sweep_ff[ADDR_W-1:0];
   end

   // Weight memory
   assign wr_en   = req_fire && !is_query;
   assign wr_data = {req_if.comp_d, req_if.comp_c, req_if.comp_b, req_if.comp_a};

   nwn_store #(
      .MAX_VECTORS (MAX_VECTORS),
      .ADDR_W      (ADDR_W)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (slot_mod[req_if.slot]),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // Distance pipeline
   nwn_dist #(
      .IDX_W (ADDR_W)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .ref_load   (ref_rd_ff),
      .rd_data    (rd_data),
      .in_valid   (s1_valid_ff),
      .in_idx     (s1_idx_ff),
      .ncomp      (ncomp_ff),
      .cand_valid (cand_valid),
      .cand_dist  (cand_dist),
      .cand_idx   (cand_idx),
      .busy       (dist_busy)
   );

   // Row of sorting cells; row ends are tied off
   assign take_row[0]        = 1'b0;
   assign valid_row[0]       = 1'b0;
   assign dist_row[0]        = '0;
   assign idx_row[0]         = '0;
   assign take_row[ROW-1]    = 1'b0;
   assign valid_row[ROW-1]   = 1'b0;
   assign dist_row[ROW-1]    = '0;
   assign idx_row[ROW-1]     = '0;

   for (genvar c = 1; c <= MAX_NEIGHBORS; c++) begin : g_cell
      nwn_cell #(
         .IDX_W (ADDR_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .cand_dist  (cand_dist),
         .cand_idx   (cand_idx),
         .prev_take  (take_row[c-1]),
         .prev_valid (valid_row[c-1]),
         .prev_dist  (dist_row[c-1]),
         .prev_idx   (idx_row[c-1]),
         .next_valid (valid_row[c+1]),
         .next_dist  (dist_row[c+1]),
         .next_idx   (idx_row[c+1]),
         .take       (take_row[c]),
         .valid      (valid_row[c]),
         .entry_dist (dist_row[c]),
         .idx        (idx_row[c])
      );
   end

   // Result item comes straight from the head cell
   assign rsp_if.neighbor_index = SLOT_BITS'(idx_row[1]);
   assign rsp_if.neighbor_rank  = RANK_BITS'(rank_ff);
   assign rsp_if.last_flag      = rank_last;

endmodule

// ===== rtl/nwn_checker.sv =====
// Port-level checks for nearest_weight_neighborhood, bound to the top level.
// Depends on nwn_pkg for the field widths.
module nwn_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [nwn_pkg::SLOT_BITS-1:0] rsp_index,
   input logic [nwn_pkg::RANK_BITS-1:0] rsp_rank,
   input logic                          rsp_last
);
   import nwn_pkg::*;

   // Stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index)
         && $stable(rsp_rank) && $stable(rsp_last))
      else $error("stalled result item changed");

   // No new item is taken while results are pending
   a_no_req_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while results pending");

   // Results of one query come back to back with rising rank
   a_rank_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && (rsp_rank == RANK_BITS'($past(rsp_rank) + 1'b1)))
      else $error("result rank did not step by one");

   // Final result ends the burst
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("results continued after last item");

   // Nothing shown straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A result shown straight after an accepted request has rank zero
   a_first_rank: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid || (rsp_rank == '0))
      else $error("first result rank not zero");

endmodule

bind nearest_weight_neighborhood nwn_checker u_nwn_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_index (rsp_if.neighbor_index),
   .rsp_rank  (rsp_if.neighbor_rank),
   .rsp_last  (rsp_if.last_flag)
);

// ===== tb/tb_nearest_weight_neighborhood.sv =====
// Testbench for the nearest weight neighbourhood search block.
// Depends on nwn_pkg, the nwn_req_if/nwn_rsp_if interfaces and nearest_weight_neighborhood.
// Directed list of loads, queries and register writes, then random phases.
module tb_nearest_weight_neighborhood;
   timeunit 1ns;
   timeprecision 1ps;
   import nwn_pkg::*;

   localparam int STORE_DEPTH    = DEF_MAX_VECTORS;
   localparam int NEIGHBOR_CAP   = DEF_MAX_NEIGHBORS;
   localparam int SETTLE_CYCLES  = STORE_DEPTH + 64;
   localparam int LONG_HOLD      = 600;
   localparam int HOLD_AFTER     = 200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam int NUM_ROWS       = 32;
   localparam int NUM_PHASES     = 5;

   typedef struct packed {
      logic [SLOT_BITS-1:0] index;
      logic [RANK_BITS-1:0] rank;
      logic                 last;
   } neighbor_type;

   // Hand-written answer for a directed query; typed clear means predicted
   typedef struct {
      bit                   typed;
      int                   count;
      logic [SLOT_BITS-1:0] near0;
      logic [SLOT_BITS-1:0] near1;
   } item_note_type;

   typedef enum { ROW_LOAD, ROW_QUERY, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type         kind;
      csr_index_type        reg_sel;
      int unsigned          reg_value;
      logic [SLOT_BITS-1:0] slot;
      weight_type           comps;
      bit                   typed;
      int                   count;
      logic [SLOT_BITS-1:0] near0;
      logic [SLOT_BITS-1:0] near1;
   } stim_row_type;

   typedef struct {
      int unsigned vectors;
      int unsigned objectives;
      int unsigned neighbors;
      int unsigned items;
   } phase_type;

   // Directed list: register rows, loads and queries
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{ROW_CSR,   CSR_VECTOR_COUNT,    2,  0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_CSR,   CSR_OBJECTIVE_COUNT, 4,  0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_CSR,   CSR_NEIGHBOR_COUNT,  2,  0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_LOAD,  CSR_VECTOR_COUNT,    0,  0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_LOAD,  CSR_VECTOR_COUNT,    0,  1,   32'hFFFFFFFF, 0, 0, 0, 0},
      '{ROW_QUERY, CSR_VECTOR_COUNT,    0,  0,   32'h00000000, 1, 2, 0, 1},
      '{ROW_QUERY, CSR_VECTOR_COUNT,    0,  1,   32'h00000000, 1, 2, 1, 0},
      // top slot, outside the searched range, still serves as reference
      '{ROW_LOAD,  CSR_VECTOR_COUNT,    0,  255, 32'h00FFFFFF, 0, 0, 0, 0},
      '{ROW_QUERY, CSR_VECTOR_COUNT,    0,  255, 32'h00000000, 1, 2, 1, 0},
      // no components compared: index order
      '{ROW_CSR,   CSR_OBJECTIVE_COUNT, 0,  0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_QUERY, CSR_VECTOR_COUNT,    0,  1,   32'h00000000, 1, 2, 0, 1},
      '{ROW_CSR,   CSR_OBJECTIVE_COUNT, 7,  0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_CSR,   CSR_NEIGHBOR_COUNT,  0,  0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_QUERY, CSR_VECTOR_COUNT,    0,  0,   32'h00000000, 1, 0, 0, 0},
      // neighbour count clipped to the cap and then to the vector count
      '{ROW_CSR,   CSR_NEIGHBOR_COUNT,  63, 0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_QUERY, CSR_VECTOR_COUNT,    0,  1,   32'h00000000, 1, 2, 1, 0},
      '{ROW_CSR,   CSR_VECTOR_COUNT,    0,  0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_QUERY, CSR_VECTOR_COUNT,    0,  255, 32'h00000000, 1, 0, 0, 0},
      '{ROW_CSR,   CSR_VECTOR_COUNT,    8,  0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_CSR,   CSR_OBJECTIVE_COUNT, 3,  0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_CSR,   CSR_NEIGHBOR_COUNT,  8,  0,   32'h00000000, 0, 0, 0, 0},
      // slots 2 and 3 differ only in the unused fourth component
      '{ROW_LOAD,  CSR_VECTOR_COUNT,    0,  2,   32'h281E140A, 0, 0, 0, 0},
      '{ROW_LOAD,  CSR_VECTOR_COUNT,    0,  3,   32'hC81E140A, 0, 0, 0, 0},
      '{ROW_LOAD,  CSR_VECTOR_COUNT,    0,  4,   32'hAA55AA55, 0, 0, 0, 0},
      '{ROW_LOAD,  CSR_VECTOR_COUNT,    0,  5,   32'h55AA55AA, 0, 0, 0, 0},
      '{ROW_LOAD,  CSR_VECTOR_COUNT,    0,  6,   32'h04030201, 0, 0, 0, 0},
      '{ROW_LOAD,  CSR_VECTOR_COUNT,    0,  7,   32'h80808080, 0, 0, 0, 0},
      '{ROW_QUERY, CSR_VECTOR_COUNT,    0,  3,   32'h00000000, 0, 0, 0, 0},
      '{ROW_QUERY, CSR_VECTOR_COUNT,    0,  7,   32'h00000000, 0, 0, 0, 0},
      '{ROW_QUERY, CSR_VECTOR_COUNT,    0,  4,   32'h00000000, 0, 0, 0, 0},
      // equal distance: lower index wins
      '{ROW_CSR,   CSR_NEIGHBOR_COUNT,  1,  0,   32'h00000000, 0, 0, 0, 0},
      '{ROW_QUERY, CSR_VECTOR_COUNT,    0,  3,   32'h00000000, 1, 1, 2, 0}
   };

   // Random phases: register settings and item counts
   phase_type phases [NUM_PHASES] = '{
      '{16,  2, 5,  35},
      '{40,  4, 32, 25},
      '{1,   1, 1,  15},
      '{511, 4, 40, 30},
      '{256, 5, 20, 25}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   nwn_req_if req_ch ();
   nwn_rsp_if rsp_ch ();

   nearest_weight_neighborhood dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_ch),
      .rsp_if         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow of the block: weight store and registers
   weight_type                stored_weights [STORE_DEPTH];
   logic [VCOUNT_BITS-1:0]    cfg_vectors;
   logic [OCOUNT_BITS-1:0]    cfg_objectives;
   logic [NCOUNT_BITS-1:0]    cfg_neighbors;

   neighbor_type   pending_neighbors [$];
   item_note_type  item_notes [$];
   item_note_type  plain_note = '{0, 0, 0, 0};
   bit             slot_loaded [STORE_DEPTH];
   int             fault_count = 0;
   int             results_taken = 0;
   int             quiet_cycles = 0;
   int             send_calm = 0;
   int             take_calm = 0;

   // Append one expected result
   function automatic void queue_expected(input logic [SLOT_BITS-1:0] near_idx,
                                          input int rank_no, input bit is_last);
      neighbor_type n;
      n = '{near_idx, RANK_BITS'(rank_no), is_last};
      pending_neighbors.insert(pending_neighbors.size(), n);
   endfunction

   // Nearest vectors to the centre slot, ties to the lower index
   function automatic void queue_nearest(input logic [SLOT_BITS-1:0] centre);
      int unsigned nvec, ncomp, nres;
      int sq_sum, diff;
      logic [DIST_W+SLOT_BITS-1:0] keys [$];
      nvec  = (cfg_vectors > STORE_DEPTH) ? STORE_DEPTH : cfg_vectors;
      ncomp = (cfg_objectives > NUM_COMPS) ? NUM_COMPS : cfg_objectives;
      nres  = (cfg_neighbors > NEIGHBOR_CAP) ? NEIGHBOR_CAP : cfg_neighbors;
      if (nres > nvec)
         nres = nvec;
      for (int unsigned i = 0; i < nvec; i++) begin
         sq_sum = 0;
         for (int unsigned k = 0; k < ncomp; k++) begin
            diff = int'(stored_weights[i][k]) - int'(stored_weights[centre][k]);
            sq_sum += diff * diff;
         end
         keys.insert(keys.size(), {DIST_W'(sq_sum), SLOT_BITS'(i)});
      end
      keys.sort();
      for (int unsigned r = 0; r < nres; r++)
         queue_expected(keys[r][SLOT_BITS-1:0], int'(r), r + 1 == nres);
   endfunction

   // Idle length: mostly none, some short, a few long, with calm stretches
   function automatic int pick_gap(inout int calm);
      int unsigned pick;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         calm = int'($urandom_range(10, 30));
         return 0;
      end
      if (pick < 55)
         return 0;
      if (pick < 88)
         return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   // Weight content: random, near or equal to a stored vector, or extremes
   function automatic weight_type make_weight(input int unsigned nvec);
      weight_type  w;
      int unsigned pick, base;
      int          c;
      pick = $urandom_range(0, 99);
      base = $urandom_range(0, nvec - 1);
      w = weight_type'($urandom);
      if (pick >= 80) begin
         for (int k = 0; k < NUM_COMPS; k++)
            if ($urandom_range(0, 2) != 0)
               w[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else if (pick >= 65) begin
         w = stored_weights[base];
      end else if (pick >= 40) begin
         for (int k = 0; k < NUM_COMPS; k++) begin
            c = int'(stored_weights[base][k]) + int'($urandom_range(0, 4)) - 2;
            if (c < 0)
               c = 0;
            else if (c > 255)
               c = 255;
            w[k] = COMP_BITS'(c);
         end
      end
      return w;
   endfunction

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%s", msg);
   endfunction

   // Offer one item after a random gap and wait for it to be taken
   task automatic send_item(input action_type act, input logic [SLOT_BITS-1:0] slot,
                            input weight_type comps, input item_note_type note);
      int gap;
      gap = pick_gap(send_calm);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.slot   <= slot;
      req_ch.comp_a <= comps[0];
      req_ch.comp_b <= comps[1];
      req_ch.comp_c <= comps[2];
      req_ch.comp_d <= comps[3];
      if (act == ACT_LOAD)
         slot_loaded[slot] = 1'b1;
      item_notes.insert(item_notes.size(), note);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_neighbors.size() != 0);
   endtask

   // Block idle: all results in, then room for a query that gives none
   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input int unsigned value);
      csr_write_en   <= 1'b1;
      csr_index      <= sel;
      csr_write_data <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(posedge clock);
   endtask

   // One random item: queries only on loaded slots, mostly in range
   task automatic random_item(input int unsigned nvec);
      logic [SLOT_BITS-1:0] slot;
      if ($urandom_range(0, 1) != 0) begin
         if ($urandom_range(0, 5) != 0)
            slot = SLOT_BITS'($urandom_range(0, nvec - 1));
         else
            do slot = SLOT_BITS'($urandom_range(0, STORE_DEPTH - 1)); while (!slot_loaded[slot]);
         send_item(ACT_QUERY, slot, weight_type'($urandom), plain_note);
      end else begin
         if ($urandom_range(0, 4) != 0)
            slot = SLOT_BITS'($urandom_range(0, nvec - 1));
         else
            slot = SLOT_BITS'($urandom_range(0, STORE_DEPTH - 1));
         send_item(ACT_LOAD, slot, make_weight(nvec), plain_note);
      end
   endtask

   // Monitor: register writes, accepted items, result check, watchdog
   always @(posedge clock) begin
      item_note_type note;
      neighbor_type  got, want;
      if (reset) begin
         cfg_vectors    = RESET_VECTOR_COUNT;
         cfg_objectives = RESET_OBJECTIVE_COUNT;
         cfg_neighbors  = RESET_NEIGHBOR_COUNT;
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_VECTOR_COUNT:    cfg_vectors    = csr_write_data[VCOUNT_BITS-1:0];
               CSR_OBJECTIVE_COUNT: cfg_objectives = csr_write_data[OCOUNT_BITS-1:0];
               CSR_NEIGHBOR_COUNT:  cfg_neighbors  = csr_write_data[NCOUNT_BITS-1:0];
               default: ;
            endcase
         end

         if (req_ch.valid && req_ch.ready) begin
            note = plain_note;
            if (item_notes.size() != 0)
               note = item_notes.pop_front();
            if (action_type'(req_ch.action) == ACT_LOAD) begin
               stored_weights[req_ch.slot] =
                  {req_ch.comp_d, req_ch.comp_c, req_ch.comp_b, req_ch.comp_a};
            end else if (note.typed) begin
               for (int r = 0; r < note.count; r++)
                  queue_expected((r == 0) ? note.near0 : note.near1, r,
                                 r + 1 == note.count);
            end else begin
               queue_nearest(req_ch.slot);
            end
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            results_taken++;
            got = '{rsp_ch.neighbor_index, rsp_ch.neighbor_rank, rsp_ch.last_flag};
            if (pending_neighbors.size() == 0) begin
               note_fault($sformatf("unexpected result: index %0d rank %0d last %0d",
                                    got.index, got.rank, got.last));
            end else begin
               want = pending_neighbors.pop_front();
               if (got.index !== want.index || got.rank !== want.rank ||
                   got.last !== want.last)
                  note_fault($sformatf({"result mismatch: expected index %0d rank %0d ",
                                        "last %0d, got index %0d rank %0d last %0d"},
                                       want.index, want.rank, want.last,
                                       got.index, got.rank, got.last));
            end
         end

         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Result side: random stalls, one long hold-off after HOLD_AFTER results
   initial begin : result_taker
      int stall;
      bit held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && results_taken >= HOLD_AFTER) begin
            held  = 1'b1;
            stall = LONG_HOLD;
         end else begin
            stall = pick_gap(take_calm);
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Request side: reset, directed list, random phases, final verdict
   initial begin : stimulus
      stim_row_type  row;
      item_note_type note;
      bit            dirty;
      int unsigned   nvec;
      req_ch.valid   = 1'b0;
      req_ch.action  = ACT_LOAD;
      req_ch.slot    = '0;
      req_ch.comp_a  = '0;
      req_ch.comp_b  = '0;
      req_ch.comp_c  = '0;
      req_ch.comp_d  = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_VECTOR_COUNT;
      csr_write_data = '0;
      foreach (stored_weights[i])
         stored_weights[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      dirty = 1'b0;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            if (dirty)
               settle();
            dirty = 1'b0;
            write_reg(row.reg_sel, row.reg_value);
         end else begin
            note = '{row.typed, row.count, row.near0, row.near1};
            send_item((row.kind == ROW_LOAD) ? ACT_LOAD : ACT_QUERY, row.slot, row.comps,
                      note);
            dirty = 1'b1;
         end
      end

      // random phases; every searched slot is loaded before any query
      foreach (phases[p]) begin
         settle();
         write_reg(CSR_VECTOR_COUNT, phases[p].vectors);
         write_reg(CSR_OBJECTIVE_COUNT, phases[p].objectives);
         write_reg(CSR_NEIGHBOR_COUNT, phases[p].neighbors);
         nvec = (phases[p].vectors > STORE_DEPTH) ? STORE_DEPTH : phases[p].vectors;
         for (int unsigned s = 0; s < nvec; s++)
            if (!slot_loaded[s])
               send_item(ACT_LOAD, SLOT_BITS'(s), make_weight(nvec), plain_note);
         for (int unsigned n = 0; n < phases[p].items; n++) begin
            // sender pauses once until every result is in
            if (p == 0 && n == phases[p].items / 2)
               drain_results();
            random_item(nvec);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_neighbors.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== nearest_weight_neighborhood.f =====
rtl/nwn_pkg.sv
rtl/nwn_channel_if.sv
rtl/nwn_store.sv
rtl/nwn_dist.sv
rtl/nwn_cell.sv
rtl/nearest_weight_neighborhood.sv
rtl/nwn_checker.sv
tb/tb_nearest_weight_neighborhood.sv
